// ===== design/srt_pkg.sv =====
// shake reversal toggle: shared types, widths, codes and reset constants
// no dependencies; imported by the interfaces and every module
`timescale 1ns / 1ps
`default_nettype none

package srt_pkg;

    localparam int AXIS_W    = 16;
    localparam int TIME_W    = 32;
    localparam int EXC_W     = 17;
    localparam int THR_W     = 16;
    localparam int NEED_W    = 8;
    localparam int MS_W      = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;

    // sum of three squares, its Q.16 radicand and the Q.8 root
    localparam int SUMSQ_W   = 32;
    localparam int RAD_W     = SUMSQ_W + 16;
    localparam int ROOT_W    = RAD_W / 2;
    localparam int REM_W     = ROOT_W + 3;
    localparam int ISQRT_STEPS = ROOT_W;
    localparam int STEP_CNT_W  = $clog2(ISQRT_STEPS);

    localparam int GRAV_W    = 25;
    localparam int DYN_W     = GRAV_W + 2;

    // shared multiplier operands and product
    localparam int MUL_A_W   = DYN_W;
    localparam int MUL_B_W   = AXIS_W + 1;
    localparam int MUL_P_W   = MUL_A_W + MUL_B_W;

    localparam int CNT_W     = 8;

    localparam logic [GRAV_W-1:0]  GRAVITY_RESET = 25'd4194304;
    localparam logic [MUL_B_W-1:0] EMA_ALPHA     = 17'd655;
    localparam int                 EMA_SHIFT     = 16;

    localparam logic [THR_W-1:0]  THRESHOLD_RESET = 16'd6000;
    localparam logic [NEED_W-1:0] NEEDED_RESET    = 8'd3;
    localparam logic [MS_W-1:0]   WINDOW_RESET    = 16'd800;
    localparam logic [MS_W-1:0]   COOLDOWN_RESET  = 16'd1500;

    localparam logic [CNT_W-1:0]  COUNT_MAX = {CNT_W{1'b1}};

    // direction of the last excursion over the threshold outside cooldown
    localparam logic [1:0] SIGN_NONE = 2'd0;
    localparam logic [1:0] SIGN_POS  = 2'd1;
    localparam logic [1:0] SIGN_NEG  = 2'd3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_THRESHOLD = 2'd0,
        CFG_NEEDED    = 2'd1,
        CFG_WINDOW    = 2'd2,
        CFG_COOLDOWN  = 2'd3
    } srt_cfg_idx_t;

    typedef struct packed {
        logic busy;
        logic done;
    } srt_sqrt_stat_t;

endpackage

`default_nettype wire

// ===== design/srt_in_if.sv =====
// sample channel: valid/ready plus three axes and a timestamp
// depends on srt_pkg
`timescale 1ns / 1ps
`default_nettype none

interface srt_in_if import srt_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [AXIS_W-1:0] accel_x;
    logic signed [AXIS_W-1:0] accel_y;
    logic signed [AXIS_W-1:0] accel_z;
    logic        [TIME_W-1:0] now_ms;

    modport source (output valid, accel_x, accel_y, accel_z, now_ms, input ready);
    modport sink   (input valid, accel_x, accel_y, accel_z, now_ms, output ready);
endinterface

`default_nettype wire

// ===== design/srt_out_if.sv =====
// result channel: valid/ready plus flag state, toggle mark and excursion
// depends on srt_pkg
`timescale 1ns / 1ps
`default_nettype none

interface srt_out_if import srt_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic                    enabled;
    logic                    toggled;
    logic signed [EXC_W-1:0] excursion;

    modport source (output valid, enabled, toggled, excursion, input ready);
    modport sink   (input valid, enabled, toggled, excursion, output ready);
endinterface

`default_nettype wire

// ===== design/srt_cfg_if.sv =====
// configuration write channel: valid/ready, register index and data
// depends on srt_pkg
`timescale 1ns / 1ps
`default_nettype none

interface srt_cfg_if import srt_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== design/shake_reversal_toggle_top.sv =====
// shake reversal toggle, top level: sequencer, gravity tracking, reversal logic
// depends on srt_pkg, the three channel interfaces, srt_mul and srt_isqrt
//
// usage
//   sample : one transaction carries accel_x/y/z (signed) and now_ms
//   result : exactly one transaction per sample: enabled, toggled, excursion
//   cfg    : register writes (0 threshold, 1 reversals needed, 2 window,
//            3 cooldown), always ready, to be issued only while idle
// flow
//   a sample passes from its transaction to its result on the result channel
//   through squaring in the one shared multiplier, the square root unit
//   (24 iterations, one root bit per cycle, then a completion flag), the
//   gravity product, gravity update, excursion and decision; sample.ready
//   stays low meanwhile, so no new sample is taken while one is in progress
//   a new sample is taken in the cycle after the result is loaded
// stall
//   the result sits in an output register; if it is still not taken when the
//   next result is ready, the block waits in its decision step
// reset
//   clears config to defaults, gravity to 16384.0, count, signs and times to
//   zero and the enable flag to on; no clearing pass is needed
`timescale 1ns / 1ps
`default_nettype none

module shake_reversal_toggle_top import srt_pkg::*; (
    input  wire logic clk,
    input  wire logic rst_n,
    srt_in_if.sink    sample,
    srt_out_if.source result,
    srt_cfg_if.sink   cfg
);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_SQ   = 7'b0000010,
        S_ROOT = 7'b0000100,
        S_EMA  = 7'b0001000,
        S_UPD  = 7'b0010000,
        S_DYN  = 7'b0100000,
        S_DEC  = 7'b1000000
    } srt_state_t;

    srt_state_t state_reg, state_next;

    // configuration
    logic [THR_W-1:0]  thr_reg;
    logic [NEED_W-1:0] need_reg;
    logic [MS_W-1:0]   window_reg;
    logic [MS_W-1:0]   cool_reg;

    // sample and datapath
    logic signed [AXIS_W-1:0] ax_reg, ay_reg, az_reg;
    logic [TIME_W-1:0]        now_reg;
    logic [2:0]               sq_cnt_reg;
    logic [SUMSQ_W-1:0]       acc_reg;
    logic signed [DYN_W-1:0]  dyn_reg;
    logic                     exceed_reg;

    // tracked state
    logic [GRAV_W-1:0] gravity_reg;
    logic [1:0]        sign_reg, sign_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [TIME_W-1:0] wstart_reg, wstart_next;
    logic [TIME_W-1:0] cool_until_reg, cool_until_next;
    logic              enable_reg, enable_next;
    logic              toggle_next;

    // output register
    logic                    out_valid_reg;
    logic                    out_enabled_reg;
    logic                    out_toggled_reg;
    logic signed [EXC_W-1:0] out_exc_reg;

    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [MUL_P_W-1:0] mul_p;
    logic signed [AXIS_W-1:0]  axis_sel;

    logic                 sqrt_start;
    logic [ROOT_W-1:0]    sqrt_root;
    srt_sqrt_stat_t       sqrt_stat;

    logic                     in_fire;
    logic                     out_load;
    logic signed [DYN_W-1:0]  ema_diff;
    logic signed [GRAV_W+3:0] grav_sum;
    logic [GRAV_W-1:0]        grav_new;
    logic signed [DYN_W-1:0]  dyn_new;
    logic [DYN_W-1:0]         dyn_abs;
    logic [TIME_W-1:0]        window32;

    assign in_fire  = sample.valid && sample.ready;
    assign out_load = (state_reg == S_DEC) && (!out_valid_reg || result.ready);
    assign window32 = TIME_W'(window_reg);

    // ---------------- shared multiplier ----------------
    always_comb
    begin
        case (sq_cnt_reg)
            3'd0:    axis_sel = ax_reg;
            3'd1:    axis_sel = ay_reg;
            default: axis_sel = az_reg;
        endcase
    end

    assign ema_diff = $signed({3'b000, sqrt_root}) - $signed({2'b00, gravity_reg});

    always_comb
    begin
        if (state_reg == S_SQ)
        begin
            mul_a = MUL_A_W'(axis_sel);
            mul_b = MUL_B_W'(axis_sel);
        end
        else
        begin
            mul_a = ema_diff;
            mul_b = $signed(EMA_ALPHA);
        end
    end

    srt_mul u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

    // ---------------- square root ----------------
    assign sqrt_start = (state_reg == S_SQ) && (sq_cnt_reg == 3'd4);

    srt_isqrt u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand ({acc_reg, 16'h0000}),
        .root     (sqrt_root),
        .stat     (sqrt_stat)
    );

    // gravity update takes floor(alpha * diff / 2^16) by arithmetic shift
    assign grav_sum = $signed({4'b0000, gravity_reg})
                    + (GRAV_W+4)'(mul_p[MUL_P_W-1:EMA_SHIFT]);
    assign grav_new = grav_sum[GRAV_W-1:0];
    assign dyn_new  = $signed({3'b000, sqrt_root}) - $signed({2'b00, gravity_reg});
    assign dyn_abs  = dyn_new[DYN_W-1] ? DYN_W'(-dyn_new) : DYN_W'(dyn_new);

    // ---------------- sequencer ----------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (in_fire) state_next = S_SQ;
            S_SQ:   if (sq_cnt_reg == 3'd4) state_next = S_ROOT;
            S_ROOT: if (sqrt_stat.done) state_next = S_EMA;
            S_EMA:  state_next = S_UPD;
            S_UPD:  state_next = S_DYN;
            S_DYN:  state_next = S_DEC;
            S_DEC:  if (out_load) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // ---------------- reversal and toggle decision ----------------
    always_comb
    begin
        logic [1:0] sgn;
        sgn             = dyn_reg[DYN_W-1] ? SIGN_NEG : SIGN_POS;
        count_next      = count_reg;
        sign_next       = sign_reg;
        wstart_next     = wstart_reg;
        cool_until_next = cool_until_reg;
        enable_next     = enable_reg;
        toggle_next     = 1'b0;
        if ((now_reg > cool_until_reg) && exceed_reg)
        begin
            if ((sgn != sign_reg) && (sign_reg != SIGN_NONE))
            begin
                if (count_reg == '0)
                    wstart_next = now_reg;
                if (count_reg != COUNT_MAX)
                    count_next = count_reg + 1'b1;
                if ((count_next >= need_reg) && ((now_reg - wstart_next) < window32))
                begin
                    enable_next     = ~enable_reg;
                    toggle_next     = 1'b1;
                    cool_until_next = now_reg + TIME_W'(cool_reg);
                    count_next      = '0;
                end
            end
            sign_next = sgn;
        end
        // stale window
        if ((count_next != '0) && ((now_reg - wstart_next) > window32))
        begin
            count_next = '0;
            sign_next  = SIGN_NONE;
        end
    end

    // ---------------- control registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            sq_cnt_reg     <= '0;
            thr_reg        <= THRESHOLD_RESET;
            need_reg       <= NEEDED_RESET;
            window_reg     <= WINDOW_RESET;
            cool_reg       <= COOLDOWN_RESET;
            gravity_reg    <= GRAVITY_RESET;
            sign_reg       <= SIGN_NONE;
            count_reg      <= '0;
            wstart_reg     <= '0;
            cool_until_reg <= '0;
            enable_reg     <= 1'b1;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    CFG_THRESHOLD: thr_reg    <= cfg.data;
                    CFG_NEEDED:    need_reg   <= cfg.data[NEED_W-1:0];
                    CFG_WINDOW:    window_reg <= cfg.data;
                    CFG_COOLDOWN:  cool_reg   <= cfg.data;
                    default:       ;
                endcase
            end

            if (in_fire)
                sq_cnt_reg <= '0;
            else if (state_reg == S_SQ)
                sq_cnt_reg <= sq_cnt_reg + 1'b1;

            if (state_reg == S_UPD)
                gravity_reg <= grav_new;

            if (out_load)
            begin
                sign_reg       <= sign_next;
                count_reg      <= count_next;
                wstart_reg     <= wstart_next;
                cool_until_reg <= cool_until_next;
                enable_reg     <= enable_next;
                out_valid_reg  <= 1'b1;
            end
            else if (result.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // ---------------- datapath registers ----------------
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            ax_reg  <= sample.accel_x;
            ay_reg  <= sample.accel_y;
            az_reg  <= sample.accel_z;
            now_reg <= sample.now_ms;
            acc_reg <= '0;
        end
        else if ((state_reg == S_SQ) && (sq_cnt_reg != 3'd0) && (sq_cnt_reg != 3'd4))
            acc_reg <= acc_reg + mul_p[SUMSQ_W-1:0];

        if (state_reg == S_DYN)
        begin
            dyn_reg    <= dyn_new;
            exceed_reg <= (dyn_abs > DYN_W'({thr_reg, 8'h00}));
        end

        if (out_load)
        begin
            out_enabled_reg <= enable_next;
            out_toggled_reg <= toggle_next;
            out_exc_reg     <= dyn_reg[EXC_W+7:8];
        end
    end

    assign sample.ready     = (state_reg == S_IDLE);
    assign cfg.ready        = 1'b1;
    assign result.valid     = out_valid_reg;
    assign result.enabled   = out_enabled_reg;
    assign result.toggled   = out_toggled_reg;
    assign result.excursion = out_exc_reg;

    // ---------------- assertions ----------------
    a_count_has_sign: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != '0) |-> (sign_reg != SIGN_NONE))
        else $error("reversal count held without a last sign");

    a_toggle_flips: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && toggle_next) |=> (enable_reg != $past(enable_reg)))
        else $error("toggle did not flip the enable flag");

    a_sqrt_in_root: assert property (@(posedge clk) disable iff (!rst_n)
        sqrt_stat.busy |-> (state_reg == S_ROOT))
        else $error("square root running outside its step");

    a_gravity_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_UPD) |=> $stable(gravity_reg))
        else $error("gravity changed outside its update step");

endmodule

`default_nettype wire

// ===== design/srt_mul.sv =====
// shared signed multiplier with registered product
// depends on srt_pkg
`timescale 1ns / 1ps
`default_nettype none

module srt_mul import srt_pkg::*; (
    input  wire logic                      clk,
    input  wire logic signed [MUL_A_W-1:0] a,
    input  wire logic signed [MUL_B_W-1:0] b,
    output logic signed      [MUL_P_W-1:0] p
);

    logic signed [MUL_P_W-1:0] p_reg;

    always_ff @(posedge clk)
    begin
        p_reg <= MUL_P_W'(a * b);
    end

    assign p = p_reg;

endmodule

`default_nettype wire

// ===== design/srt_isqrt.sv =====
// bit-serial floor square root, two radicand bits per cycle
// depends on srt_pkg
`timescale 1ns / 1ps
`default_nettype none

module srt_isqrt import srt_pkg::*; (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [RAD_W-1:0]  radicand,
    output logic      [ROOT_W-1:0] root,
    output srt_sqrt_stat_t         stat
);

    logic [RAD_W-1:0]      rad_reg;
    logic [REM_W-1:0]      rem_reg;
    logic [ROOT_W-1:0]     root_reg;
    logic [STEP_CNT_W-1:0] step_reg;
    logic                  busy_reg;
    logic                  done_reg;

    logic [REM_W-1:0] rem_sh;
    logic [REM_W-1:0] trial;
    logic             fits;

    assign rem_sh = {rem_reg[REM_W-3:0], rad_reg[RAD_W-1 -: 2]};
    assign trial  = {1'b0, root_reg, 2'b01};
    assign fits   = (rem_sh >= trial);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == STEP_CNT_W'(ISQRT_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg <= {rad_reg[RAD_W-3:0], 2'b00};
            if (fits)
            begin
                rem_reg  <= rem_sh - trial;
                root_reg <= {root_reg[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= rem_sh;
                root_reg <= {root_reg[ROOT_W-2:0], 1'b0};
            end
        end
    end

    assign root      = root_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

`default_nettype wire

// ===== verif/shake_reversal_toggle_checker.sv =====
// shake reversal toggle: passive checker that predicts one result per sample
// and compares it with the result channel; depends on srt_pkg and the channel interfaces
`timescale 1ns / 1ps

module shake_reversal_toggle_checker
    import srt_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    srt_in_if         sample,
    srt_out_if        result,
    srt_cfg_if        cfg,
    output int        mismatches,
    output int        pending
);

    localparam int REPORT_CAP = 200;

    typedef struct packed {
        logic             enabled;
        logic             toggled;
        logic [EXC_W-1:0] excursion;
    } verdict_t;

    verdict_t verdict_q[$];

    // register copies
    logic [THR_W-1:0]  threshold;
    logic [NEED_W-1:0] needed;
    logic [MS_W-1:0]   window_len;
    logic [MS_W-1:0]   cooldown_len;

    // detector state
    logic [GRAV_W-1:0] gravity;
    logic [1:0]        last_dir;
    logic [CNT_W-1:0]  reversals;
    logic [TIME_W-1:0] window_open;
    logic [TIME_W-1:0] quiet_until;
    logic              flag_on;

    // floor of sqrt(sum_sq) in Q.8, one root bit at a time from the top
    function automatic logic [ROOT_W-1:0] q8_magnitude(input logic [SUMSQ_W-1:0] sum_sq);
        logic [RAD_W-1:0]  rad;
        logic [ROOT_W-1:0] root;
        logic [ROOT_W-1:0] trial;
        rad  = {sum_sq, 16'd0};
        root = '0;
        for (int b = ROOT_W - 1; b >= 0; b--)
        begin
            trial = root | (ROOT_W'(1) << b);
            if (RAD_W'(trial) * RAD_W'(trial) <= rad)
                root = trial;
        end
        return root;
    endfunction

    function automatic verdict_t detect_shake(input logic signed [AXIS_W-1:0] ax,
                                              input logic signed [AXIS_W-1:0] ay,
                                              input logic signed [AXIS_W-1:0] az,
                                              input logic [TIME_W-1:0] now);
        longint            sx;
        longint            sy;
        longint            sz;
        longint            mag;
        longint            base;
        longint            dyn;
        longint            dyn_abs;
        logic [1:0]        dir;
        logic [TIME_W-1:0] elapsed;
        verdict_t          v;
        sx   = ax;
        sy   = ay;
        sz   = az;
        mag  = q8_magnitude(SUMSQ_W'(sx * sx + sy * sy + sz * sz));
        // ema step, arithmetic shift gives the floor
        base = gravity;
        base = base + ((longint'(EMA_ALPHA) * (mag - base)) >>> EMA_SHIFT);
        gravity = GRAV_W'(base);
        dyn     = mag - longint'(gravity);
        dyn_abs = (dyn < 0) ? -dyn : dyn;
        v.toggled = 1'b0;

        if (now > quiet_until && dyn_abs > (longint'(threshold) << 8))
        begin
            dir = (dyn > 0) ? SIGN_POS : SIGN_NEG;
            if (dir != last_dir && last_dir != SIGN_NONE)
            begin
                if (reversals == '0)
                    window_open = now;
                if (reversals != COUNT_MAX)
                    reversals = reversals + 1'b1;
                elapsed = now - window_open;
                if (reversals >= needed && elapsed < TIME_W'(window_len))
                begin
                    flag_on     = ~flag_on;
                    v.toggled   = 1'b1;
                    quiet_until = now + TIME_W'(cooldown_len);
                    reversals   = '0;
                end
            end
            last_dir = dir;
        end

        // stale window
        elapsed = now - window_open;
        if (reversals != '0 && elapsed > TIME_W'(window_len))
        begin
            reversals = '0;
            last_dir  = SIGN_NONE;
        end

        v.enabled   = flag_on;
        v.excursion = EXC_W'(dyn >>> 8);
        return v;
    endfunction

    task automatic report(input string field, input longint want, input longint got);
        mismatches++;
        if (mismatches <= REPORT_CAP)
            $display("%0t: %s expected %0d got %0d", $time, field, want, got);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        verdict_t want;
        if (!rst_n)
        begin
            threshold    = THRESHOLD_RESET;
            needed       = NEEDED_RESET;
            window_len   = WINDOW_RESET;
            cooldown_len = COOLDOWN_RESET;
            gravity      = GRAVITY_RESET;
            last_dir     = SIGN_NONE;
            reversals    = '0;
            window_open  = '0;
            quiet_until  = '0;
            flag_on      = 1'b1;
            verdict_q.delete();
            mismatches   = 0;
            pending      = 0;
        end
        else
        begin
            if (result.valid && result.ready)
            begin
                if (verdict_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_CAP)
                        $display("%0t: result transaction with none expected, got %b/%b/%0d",
                                 $time, result.enabled, result.toggled, result.excursion);
                end
                else
                begin
                    want = verdict_q.pop_front();
                    if (result.enabled !== want.enabled)
                        report("enabled", want.enabled, result.enabled);
                    if (result.toggled !== want.toggled)
                        report("toggled", want.toggled, result.toggled);
                    if (result.excursion !== want.excursion)
                        report("excursion", $signed(want.excursion), result.excursion);
                end
            end

            if (sample.valid && sample.ready)
                verdict_q.push_back(detect_shake(sample.accel_x, sample.accel_y,
                                                 sample.accel_z, sample.now_ms));

            if (cfg.valid && cfg.ready)
            begin
                case (srt_cfg_idx_t'(cfg.index))
                    CFG_THRESHOLD: threshold    = cfg.data[THR_W-1:0];
                    CFG_NEEDED:    needed       = cfg.data[NEED_W-1:0];
                    CFG_WINDOW:    window_len   = cfg.data[MS_W-1:0];
                    CFG_COOLDOWN:  cooldown_len = cfg.data[MS_W-1:0];
                    default:       ;
                endcase
            end

            pending = verdict_q.size();
        end
    end

endmodule

// ===== verif/shake_reversal_toggle_top_tb.sv =====
// shake reversal toggle testbench top: clock, reset, sample and register stimulus,
// random back-pressure and the verdict; depends on srt_pkg, the interfaces and the checker
`timescale 1ns / 1ps

module shake_reversal_toggle_top_tb;

    import srt_pkg::*;

    localparam int CYCLE_LIMIT   = 1000000;
    localparam int DRAIN_CYCLES  = 40;

    typedef enum logic [1:0] {
        MOTION_PEAK,
        MOTION_TROUGH,
        MOTION_REST,
        MOTION_NOISE
    } motion_t;

    logic              clk;
    logic              rst_n;
    logic              calm = 1'b0;
    logic [TIME_W-1:0] clock_ms;
    int                cycles = 0;
    int                mismatches;
    int                pending;

    srt_in_if  sample_ch ();
    srt_out_if result_ch ();
    srt_cfg_if cfg_ch ();

    shake_reversal_toggle_top dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    shake_reversal_toggle_checker watch
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .sample     (sample_ch),
        .result     (result_ch),
        .cfg        (cfg_ch),
        .mismatches (mismatches),
        .pending    (pending)
    );

    initial clk = 1'b0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles = cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("[shake_reversal_toggle_top] ERROR");
            $finish;
        end
    end

    // mostly short idles, now and then long enough to cover a whole sample
    function automatic int idle_length();
        int r;
        r = $urandom_range(99);
        if (r < 50)
            return 0;
        else if (r < 85)
            return $urandom_range(3, 1);
        else if (r < 96)
            return $urandom_range(15, 4);
        return $urandom_range(70, 20);
    endfunction

    function automatic logic [TIME_W-1:0] time_step();
        int r;
        r = $urandom_range(99);
        if (r < 5)
            return '0;
        else if (r < 80)
            return $urandom_range(60, 5);
        else if (r < 92)
            return $urandom_range(400, 61);
        else if (r < 98)
            return $urandom_range(3000, 700);
        return $urandom;
    endfunction

    function automatic logic signed [AXIS_W-1:0] swing(input int lo, input int hi);
        logic signed [AXIS_W-1:0] m;
        m = AXIS_W'($urandom_range(hi, lo));
        return $urandom_range(1) ? -m : m;
    endfunction

    // result back-pressure
    initial
    begin
        int stall;
        stall = 0;
        result_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall == 0 && !calm && $urandom_range(99) < 25)
                stall = idle_length();
            if (stall > 0)
            begin
                result_ch.ready = 1'b0;
                stall--;
            end
            else
                result_ch.ready = 1'b1;
        end
    end

    task automatic send_sample(input logic signed [AXIS_W-1:0] x,
                               input logic signed [AXIS_W-1:0] y,
                               input logic signed [AXIS_W-1:0] z,
                               input logic [TIME_W-1:0] now);
        int gap;
        gap = calm ? 0 : idle_length();
        @(negedge clk);
        if (gap > 0)
        begin
            sample_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        sample_ch.accel_x = x;
        sample_ch.accel_y = y;
        sample_ch.accel_z = z;
        sample_ch.now_ms  = now;
        sample_ch.valid   = 1'b1;
        @(posedge clk);
        while (!sample_ch.ready)
            @(posedge clk);
    endtask

    // stop sending and wait for every outstanding result
    task automatic settle();
        @(negedge clk);
        sample_ch.valid = 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(input srt_cfg_idx_t idx, input logic [CFG_DAT_W-1:0] value);
        @(negedge clk);
        cfg_ch.index = idx;
        cfg_ch.data  = value;
        cfg_ch.valid = 1'b1;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        @(negedge clk);
        cfg_ch.valid = 1'b0;
    endtask

    task automatic configure(input int thr, input int need, input int win, input int cool);
        settle();
        write_reg(CFG_THRESHOLD, CFG_DAT_W'(thr));
        write_reg(CFG_NEEDED, CFG_DAT_W'(need));
        write_reg(CFG_WINDOW, CFG_DAT_W'(win));
        write_reg(CFG_COOLDOWN, CFG_DAT_W'(cool));
    endtask

    task automatic emit(input motion_t m);
        int                       a;
        logic signed [AXIS_W-1:0] ax [3];
        a = $urandom_range(2);
        case (m)
            MOTION_PEAK:
            begin
                if ($urandom_range(4) == 0)
                    for (int i = 0; i < 3; i++) ax[i] = swing(15000, 32767);
                else
                begin
                    for (int i = 0; i < 3; i++) ax[i] = swing(0, 3000);
                    ax[a] = swing(26000, 32767);
                end
            end
            MOTION_TROUGH:
                for (int i = 0; i < 3; i++) ax[i] = swing(0, 1500);
            MOTION_REST:
            begin
                for (int i = 0; i < 3; i++) ax[i] = swing(0, 800);
                ax[a] = swing(15500, 17300);
            end
            default:
                for (int i = 0; i < 3; i++) ax[i] = AXIS_W'($urandom);
        endcase
        if (m == MOTION_NOISE && $urandom_range(1) == 1)
            clock_ms = $urandom;
        else
            clock_ms = clock_ms + time_step();
        send_sample(ax[0], ax[1], ax[2], clock_ms);
    endtask

    task automatic run_phase(input int thr, input int need, input int win, input int cool,
                             input int items, input bit long_runs, input bit quiet);
        int      made;
        int      run;
        int      r;
        motion_t m;
        configure(thr, need, win, cool);
        calm = quiet;
        made = 0;
        while (made < items)
        begin
            r = $urandom_range(99);
            if (long_runs || r < 65)
            begin
                // alternating peaks and troughs, now and then a broken pattern
                run = long_runs ? items - made : $urandom_range(16, 3);
                m   = $urandom_range(1) ? MOTION_PEAK : MOTION_TROUGH;
                for (int i = 0; i < run && made < items; i++)
                begin
                    emit(m);
                    made++;
                    if ($urandom_range(9) != 0)
                        m = (m == MOTION_PEAK) ? MOTION_TROUGH : MOTION_PEAK;
                end
            end
            else
            begin
                run = (r < 85) ? $urandom_range(6, 2) : $urandom_range(3, 1);
                for (int i = 0; i < run && made < items; i++)
                begin
                    emit((r < 85) ? MOTION_REST : MOTION_NOISE);
                    made++;
                end
            end
        end
        calm = 1'b0;
    endtask

    initial
    begin
        rst_n             = 1'b0;
        sample_ch.valid   = 1'b0;
        sample_ch.accel_x = '0;
        sample_ch.accel_y = '0;
        sample_ch.accel_z = '0;
        sample_ch.now_ms  = '0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.index      = CFG_THRESHOLD;
        cfg_ch.data       = '0;
        clock_ms          = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // magnitude exactly on the reset baseline
        send_sample(16384, 0, 0, 32'd10);
        send_sample(0, 0, -16384, 32'd20);
        // zero threshold: a zero excursion must not count, the smallest one must
        settle();
        write_reg(CFG_THRESHOLD, '0);
        send_sample(0, 16384, 0, 32'd30);
        send_sample(-16384, 0, 0, 32'd40);
        send_sample(16385, 0, 0, 32'd50);
        send_sample(16383, 0, 0, 32'd60);
        settle();
        write_reg(CFG_THRESHOLD, CFG_DAT_W'(THRESHOLD_RESET));

        // reversals up to a toggle, then the cooldown edge
        send_sample(0, 0, 0, 32'd100);
        send_sample(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 32'd120);
        send_sample(16'sh8000, 16'sh8000, 16'sh8000, 32'd140);
        send_sample(0, 0, 0, 32'd160);
        send_sample(16'sh7FFF, 0, 0, 32'd180);
        send_sample(0, 0, 0, 32'd1660);
        send_sample(16'sh7FFF, 0, 0, 32'd1661);

        // reversals across the timestamp wrap
        send_sample(16'sh8000, 0, 0, 32'hFFFF_FF00);
        send_sample(0, 0, 0, 32'hFFFF_FF80);
        send_sample(0, 16'sh7FFF, 16'sh8000, 32'h0000_0040);
        send_sample(1, -1, 0, 32'h0000_0100);
        send_sample(16'sh7FFF, 16'sh8000, 16'sh5555, 32'h0000_0180);

        // stale window clears a started count
        send_sample(0, 0, 0, 32'h0000_2000);
        send_sample(16'sh7FFF, 16'sh7FFF, 0, 32'h0000_2010);
        send_sample(16'shAAAA, 0, 0, 32'h0000_2394);
        send_sample(16384, 0, 0, 32'h0000_3000);

        clock_ms = 32'h0001_0000;
        run_phase(6000, 3, 800, 1500, 60, 1'b0, 1'b0);
        run_phase(0, 1, 0, 0, 60, 1'b0, 1'b0);
        run_phase(65535, 255, 65535, 65535, 40, 1'b0, 1'b1);
        run_phase(4000, 0, 500, 200, 60, 1'b0, 1'b0);
        clock_ms = 32'hFFFF_FFFF - $urandom_range(3000);
        run_phase(3000, 2, 65535, 0, 70, 1'b0, 1'b0);
        run_phase(5000, 40, 65535, 100, 160, 1'b1, 1'b0);
        run_phase($urandom_range(10000, 2000), $urandom_range(12, 1),
                  $urandom_range(3000, 100), $urandom_range(3000, 0), 70, 1'b0, 1'b1);
        run_phase(1, 1, 65535, 65535, 60, 1'b0, 1'b0);
        run_phase($urandom_range(10000, 2000), $urandom_range(12, 1),
                  $urandom_range(3000, 100), $urandom_range(3000, 0), 60, 1'b0, 1'b0);

        settle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("[shake_reversal_toggle_top] OK");
        else
            $display("[shake_reversal_toggle_top] ERROR");
        $finish;
    end

endmodule
